FILE: design/fgc_pkg.sv
package fgc_pkg;

  typedef struct packed {
    logic [63:0] start_lba;
    logic [63:0] sector_count;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  sectors_per_cluster;
    logic [25:0] fat_sectors;
    logic [31:0] cluster_count;
    logic [31:0] data_start_sector;
    logic [63:0] data_start_lba;
  } out_t;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_SMALL   = 2'd2;

  localparam logic [1:0] SPC_1  = 2'd0;
  localparam logic [1:0] SPC_8  = 2'd1;
  localparam logic [1:0] SPC_16 = 2'd2;

  localparam logic [7:0] REG_RESERVED = 8'd0;
  localparam logic [7:0] REG_COPIES   = 8'd1;

  localparam logic [31:0] SPC_SMALL_LIMIT = 32'd524288;
  localparam logic [31:0] SPC_MID_LIMIT   = 32'd16777216;
  localparam logic [63:0] MIN_SECTORS     = 64'd65536;
  localparam logic [63:0] MAX_SECTORS     = 64'hFFFF_FFFF;
  localparam logic [31:0] MIN_CLUSTERS    = 32'd65525;

endpackage

FILE: design/fgc_cluster_unit.sv
module fgc_cluster_unit (
  input  logic [31:0] total,
  input  logic [1:0]  spc_sel,
  input  logic [25:0] fat,
  input  logic [15:0] reserved,
  input  logic [1:0]  copies,
  output logic [31:0] clusters,
  output logic [27:0] overhead
);
  import fgc_pkg::*;

  logic [27:0] fat_x1;
  logic [27:0] fat_x2;
  logic [31:0] data;

  assign fat_x1 = copies[0] ? {2'b00, fat} : 28'd0;
  assign fat_x2 = copies[1] ? {1'b0, fat, 1'b0} : 28'd0;
  assign overhead = {12'd0, reserved} + fat_x1 + fat_x2;

  // data area saturates at zero
  assign data = ({4'd0, overhead} >= total) ? 32'd0 : total - {4'd0, overhead};

  always_comb begin
    case (spc_sel)
      SPC_8:   clusters = data >> 3;
      SPC_16:  clusters = data >> 4;
      default: clusters = data;
    endcase
  end

endmodule

FILE: design/fat32_geometry_calc_core.sv
// FAT32 layout calculator. Pulse start with busy low to hand in one item
// (start LBA, sector count); busy then stays high through the size check, the
// FAT-size loop (up to four updates, none when the data area is all but empty) and
// the finish, or only the check for a rejected size. Each step of the FAT-size loop
// runs the one shared cluster unit (overhead add, saturating subtract, shift)
// or the FAT-size update. The result appears on out_item for exactly one cycle
// with out_valid high, in the cycle busy falls; the receiver cannot stall it,
// so it must take it then. Configuration writes are always ready and must only
// be made while busy is low.
module fat32_geometry_calc_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  fgc_pkg::in_t  in_item,
  output logic          out_valid,
  output fgc_pkg::out_t out_item,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [7:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import fgc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_CLU  = 3'd2;
  localparam logic [2:0] ST_NXT  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [15:0] reserved_r;
  logic [1:0]  copies_r;
  in_t         item_r;
  logic [31:0] total_r, total_nxt;
  logic [1:0]  spc_sel_r, spc_sel_nxt;
  logic [25:0] fat_r, fat_nxt;
  logic [31:0] clusters_r, clusters_nxt;
  logic [27:0] overhead_r, overhead_nxt;
  logic [1:0]  pass_r, pass_nxt;
  logic        last_r, last_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  logic [31:0] unit_clusters;
  logic [27:0] unit_overhead;
  logic [32:0] next_sum;
  logic [25:0] next_fat;
  logic [4:0]  spc_val;

  fgc_cluster_unit u_unit (
    .total    (total_r),
    .spc_sel  (spc_sel_r),
    .fat      (fat_r),
    .reserved (reserved_r),
    .copies   (copies_r),
    .clusters (unit_clusters),
    .overhead (unit_overhead)
  );

  // ceil((clusters + 2) * 4 / 512)
  assign next_sum = {1'b0, clusters_r} + 33'd129;
  assign next_fat = next_sum[32:7];

  always_comb begin
    case (spc_sel_r)
      SPC_8:   spc_val = 5'd8;
      SPC_16:  spc_val = 5'd16;
      default: spc_val = 5'd1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    spc_sel_nxt   = spc_sel_r;
    fat_nxt       = fat_r;
    clusters_nxt  = clusters_r;
    overhead_nxt  = overhead_r;
    pass_nxt      = pass_r;
    last_nxt      = last_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (item_r.sector_count > MAX_SECTORS || item_r.sector_count < MIN_SECTORS) begin
          out_nxt        = '0;
          out_nxt.status = STATUS_INVALID;
          out_valid_nxt  = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          total_nxt = item_r.sector_count[31:0];
          if (item_r.sector_count[31:0] < SPC_SMALL_LIMIT) spc_sel_nxt = SPC_1;
          else if (item_r.sector_count[31:0] < SPC_MID_LIMIT) spc_sel_nxt = SPC_8;
          else spc_sel_nxt = SPC_16;
          fat_nxt   = 26'd1;
          pass_nxt  = 2'd0;
          last_nxt  = 1'b0;
          state_nxt = ST_CLU;
        end
      end
      ST_CLU: begin
        clusters_nxt = unit_clusters;
        overhead_nxt = unit_overhead;
        state_nxt    = last_r ? ST_FIN : ST_NXT;
      end
      ST_NXT: begin
        if (next_fat <= fat_r) begin
          state_nxt = ST_FIN;
        end else begin
          fat_nxt   = next_fat;
          pass_nxt  = pass_r + 2'd1;
          last_nxt  = (pass_r == 2'd3);
          state_nxt = ST_CLU;
        end
      end
      ST_FIN: begin
        out_nxt = '0;
        if (clusters_r < MIN_CLUSTERS) begin
          out_nxt.status = STATUS_SMALL;
        end else begin
          out_nxt.status              = STATUS_OK;
          out_nxt.sectors_per_cluster = spc_val;
          out_nxt.fat_sectors         = fat_r;
          out_nxt.cluster_count       = clusters_r;
          out_nxt.data_start_sector   = {4'd0, overhead_r};
          out_nxt.data_start_lba      = item_r.start_lba + {36'd0, overhead_r};
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pass_r      <= 2'd0;
      last_r      <= 1'b0;
      reserved_r  <= 16'd32;
      copies_r    <= 2'd2;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pass_r      <= pass_nxt;
      last_r      <= last_nxt;
      if (cfg_valid) begin
        if (cfg_index == REG_RESERVED) reserved_r <= cfg_data;
        else if (cfg_index == REG_COPIES) copies_r <= cfg_data[1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == ST_IDLE) item_r <= in_item;
    total_r    <= total_nxt;
    spc_sel_r  <= spc_sel_nxt;
    fat_r      <= fat_nxt;
    clusters_r <= clusters_nxt;
    overhead_r <= overhead_nxt;
    out_r      <= out_nxt;
  end

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(state_r) == ST_FIN || $past(state_r) == ST_CHK))
    else $error("result strobe without finishing step");

  a_ok_clusters: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STATUS_OK) |-> out_item.cluster_count >= MIN_CLUSTERS)
    else $error("success reported with too few clusters");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STATUS_OK) |->
      (out_item.fat_sectors == '0 && out_item.cluster_count == '0 &&
       out_item.data_start_lba == '0 && out_item.sectors_per_cluster == '0))
    else $error("failure result carries layout fields");

  a_fat_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NXT && state_nxt == ST_CLU) |=> fat_r > $past(fat_r))
    else $error("FAT size update did not grow");

endmodule

FILE: sim/fat32_geometry_calc_core_tb.sv
`timescale 1ns / 100ps

module fat32_geometry_calc_core_tb;
  import fgc_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 190;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_t         in_item;
  logic        out_valid;
  out_t        out_item;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_index;
  logic [15:0] cfg_data;

  logic [15:0] rsv_sectors;
  logic [1:0]  fat_copy_count;
  out_t        layout_due[$];
  int          mismatches = 0;
  int          cycles = 0;

  fat32_geometry_calc_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("fat32_geometry_calc_core_tb: errors");
      $finish;
    end
  end

  // data clusters left once the reserved area and every FAT copy are taken out
  function automatic logic [63:0] clusters_left(logic [63:0] total, logic [63:0] spc,
                                                logic [63:0] fat);
    logic [63:0] overhead;
    overhead = 64'(rsv_sectors) + 64'(fat_copy_count) * fat;
    if (overhead >= total) return 64'd0;
    return (total - overhead) / spc;
  endfunction

  function automatic out_t predict_layout(in_t it);
    out_t        r;
    logic [63:0] total;
    logic [63:0] spc;
    logic [63:0] fat;
    logic [63:0] grown;
    logic [63:0] clus;
    logic [63:0] dstart;
    logic        settled;
    r = '0;
    total = it.sector_count;
    if (total > MAX_SECTORS || total < MIN_SECTORS) begin
      r.status = STATUS_INVALID;
      return r;
    end
    if (total < 64'(SPC_SMALL_LIMIT)) spc = 64'd1;
    else if (total < 64'(SPC_MID_LIMIT)) spc = 64'd8;
    else spc = 64'd16;
    fat = 64'd1;
    settled = 1'b0;
    for (int pass = 0; pass < 4; pass++) begin
      if (!settled) begin
        clus  = clusters_left(total, spc, fat);
        grown = ((clus + 64'd2) * 64'd4 + 64'd511) / 64'd512;
        if (grown <= fat) settled = 1'b1;
        else fat = grown;
      end
    end
    clus = clusters_left(total, spc, fat);
    if (clus < 64'(MIN_CLUSTERS)) begin
      r.status = STATUS_SMALL;
      return r;
    end
    dstart = 64'(rsv_sectors) + 64'(fat_copy_count) * fat;
    r.status              = STATUS_OK;
    r.sectors_per_cluster = spc[4:0];
    r.fat_sectors         = fat[25:0];
    r.cluster_count       = clus[31:0];
    r.data_start_sector   = dstart[31:0];
    r.data_start_lba      = it.start_lba + dstart;
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (layout_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with none due: %p", $realtime, out_item);
      end else begin
        want = layout_due.pop_front();
        if (out_item.status !== want.status ||
            out_item.sectors_per_cluster !== want.sectors_per_cluster ||
            out_item.fat_sectors !== want.fat_sectors ||
            out_item.cluster_count !== want.cluster_count ||
            out_item.data_start_sector !== want.data_start_sector ||
            out_item.data_start_lba !== want.data_start_lba) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: layout mismatch", $realtime);
            $display("  exp st %0d spc %0d fat %0d clus %0d dss %0d lba %h", want.status,
                     want.sectors_per_cluster, want.fat_sectors, want.cluster_count,
                     want.data_start_sector, want.data_start_lba);
            $display("  got st %0d spc %0d fat %0d clus %0d dss %0d lba %h",
                     out_item.status, out_item.sectors_per_cluster, out_item.fat_sectors,
                     out_item.cluster_count, out_item.data_start_sector,
                     out_item.data_start_lba);
          end
        end
      end
    end
  end

  task automatic send_item(input logic [63:0] lba, input logic [63:0] count);
    in_t it;
    it.start_lba    = lba;
    it.sector_count = count;
    @(negedge clk);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    layout_due.push_back(predict_layout(it));
  endtask

  task automatic hold_start(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_results();
    hold_start(1);
    while (layout_due.size() != 0) @(posedge clk);
  endtask

  // idle window for register writes
  task automatic drain();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_RESERVED: rsv_sectors = val;
      REG_COPIES:   fat_copy_count = val[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // copies register keeps only its low bits; upper data bits are random
  task automatic set_layout(input logic [15:0] rsv, input logic [1:0] copies);
    drain();
    write_reg(REG_RESERVED, rsv);
    write_reg(REG_COPIES, {14'($urandom), copies});
  endtask

  function automatic logic [63:0] random_lba();
    if ($urandom_range(0, 7) == 0)
      return 64'hFFFF_FFFF_FFFF_0000 + 64'($urandom_range(0, 65535));
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] random_count();
    logic [63:0] base;
    case ($urandom_range(0, 9))
      0: return 64'($urandom_range(0, 65535));
      1: return {$urandom_range(1, 32'hFFFF_FFFF), $urandom};
      2: return 64'($urandom_range(65536, 140000));
      3: begin
        base = $urandom_range(0, 1) ? 64'(SPC_MID_LIMIT) : 64'(SPC_SMALL_LIMIT);
        return base - 64'd2000 + 64'($urandom_range(0, 4000));
      end
      4, 5: return 64'($urandom_range(65536, 524287));
      6, 7: return 64'($urandom_range(524288, 16777215));
      default: return 64'($urandom_range(16777216, 32'hFFFF_FFFF));
    endcase
  endfunction

  task automatic test_invalid_sizes();
    send_item(random_lba(), 64'd0);
    send_item(random_lba(), MIN_SECTORS - 64'd1);
    send_item(random_lba(), MAX_SECTORS + 64'd1);
    send_item(random_lba(), {64{1'b1}});
    send_item(random_lba(), 64'h8000_0000_0001_0000);
  endtask

  task automatic test_cluster_sizes();
    send_item(64'd0, MIN_SECTORS);
    send_item(64'd2048, 64'(SPC_SMALL_LIMIT) - 64'd1);
    send_item(64'd2048, 64'(SPC_SMALL_LIMIT));
    send_item(64'd63, 64'(SPC_MID_LIMIT) - 64'd1);
    send_item(64'd63, 64'(SPC_MID_LIMIT));
    send_item(64'd1, MAX_SECTORS);
  endtask

  // cluster count reaches the FAT32 minimum at 66599 sectors at reset values
  task automatic test_min_clusters();
    send_item(64'd0, 64'd66598);
    send_item(64'd0, 64'd66599);
    send_item(64'd0, 64'd66600);
  endtask

  task automatic test_lba_wrap();
    send_item({64{1'b1}}, 64'd1000000);
    send_item(64'hFFFF_FFFF_FFFF_F000, MAX_SECTORS);
  endtask

  task automatic test_register_extremes();
    set_layout(16'hFFFF, 2'd3);
    send_item(random_lba(), MIN_SECTORS);
    send_item(random_lba(), 64'd140000);
    set_layout(16'd0, 2'd0);
    send_item(random_lba(), MIN_SECTORS);
    send_item(random_lba(), MAX_SECTORS);
    set_layout(16'd0, 2'd3);
    send_item(random_lba(), MAX_SECTORS);
    set_layout(16'd1, 2'd1);
    send_item(random_lba(), MIN_SECTORS);
    drain();
    // unmapped index, must leave the layout alone
    write_reg(8'($urandom_range(2, 255)), 16'($urandom));
    send_item(random_lba(), 64'd600000);
  endtask

  task automatic test_random_traffic();
    int sent;
    int burst;
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_layout(16'd32, 2'd2);
        1: set_layout(16'd0, 2'd0);
        2: set_layout(16'hFFFF, 2'd3);
        3: set_layout(16'd1, 2'd1);
        default: set_layout(16'($urandom), 2'($urandom));
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        burst = $urandom_range(1, 16);
        repeat (burst) begin
          if (sent < PHASE_ITEMS) begin
            send_item(random_lba(), random_count());
            sent++;
          end
        end
        case ($urandom_range(0, 7))
          0: wait_results();
          1, 2: ;
          default: hold_start($urandom_range(1, 10));
        endcase
      end
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_item        = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    rsv_sectors    = 16'd32;
    fat_copy_count = 2'd2;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_invalid_sizes();
    test_cluster_sizes();
    test_min_clusters();
    test_lba_wrap();
    test_register_extremes();
    test_random_traffic();

    drain();
    if (mismatches == 0 && layout_due.size() == 0) begin
      $display("fat32_geometry_calc_core_tb: clean");
    end else begin
      $display("fat32_geometry_calc_core_tb: errors");
    end
    $finish;
  end

endmodule
